FILE: src/jsv_pkg.sv
// Shared constants for the JSON syntax checker: nesting limit, derived widths,
// byte codes and the letter tables of the true/false/null literals.
// No dependencies.
package jsv_pkg;

   localparam int NEST_LIMIT = 16;
   localparam int LEVEL_W    = $clog2(NEST_LIMIT + 2);
   localparam int KIND_DEPTH = NEST_LIMIT + 1;
   localparam int KIND_W     = (KIND_DEPTH > 1) ? $clog2(KIND_DEPTH) : 1;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_E   = 8'h65;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_U   = 8'h75;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_E   = 8'h45;
   localparam logic [7:0] CH_UC_F   = 8'h46;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [2:0] HEX_DIGITS = 3'd4;

   typedef enum logic [1:0] {
      WORD_TRUE  = 2'd0,
      WORD_FALSE = 2'd1,
      WORD_NULL  = 2'd2
   } word_type;

   function automatic logic [2:0] word_len(word_type sel);
      case (sel)
         WORD_FALSE: return 3'd5;
         default:    return 3'd4;
      endcase
   endfunction

   // Expected letter at a position; positions past the end give a null byte.
   function automatic logic [7:0] word_char(word_type sel, logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (sel)
         WORD_TRUE: begin
            case (pos)
               3'd0: ch = "t";
               3'd1: ch = "r";
               3'd2: ch = "u";
               3'd3: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         WORD_FALSE: begin
            case (pos)
               3'd0: ch = "f";
               3'd1: ch = "a";
               3'd2: ch = "l";
               3'd3: ch = "s";
               3'd4: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         WORD_NULL: begin
            case (pos)
               3'd0: ch = "n";
               3'd1: ch = "u";
               3'd2: ch = "l";
               3'd3: ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: src/json_syntax_validator_top.sv
// Top level of the JSON syntax checker: input register, one-pass parser
// update and verdict register.
// Depends on jsv_pkg.
//
// Usage:
//   Input channel (req_): one document byte per transaction, req_last_byte
//   marks the final byte. Result channel (rsp_): one transaction per
//   document, carrying rsp_doc_valid (1 = well formed). Bytes that are not
//   last produce no result.
// Path: a byte is captured into the input register on acceptance; the parser
//   state then updates from that register and, for a last byte, once the output
//   register is free, the verdict lands in the output register, which drives
//   rsp_valid.
// Throughput: one byte per cycle while req_stall is low; the parser state
//   (mode, counters and the container-kind stack push or pop) updates per accepted byte.
// Stall: while rsp_stall holds a verdict, bytes that are not last keep
//   flowing; a waiting last byte holds in the input register and req_stall
//   rises until the output register frees up.
// Reset: synchronous, active high; clears the parser to expect a top-level
//   value and empties both registers. The container-kind stack is not
//   cleared, only entries below the nesting level are ever read.
module json_syntax_validator_top
   import jsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_doc_valid
);

   typedef enum logic [4:0] {
      M_VALUE     = 5'd0,
      M_ARR_FIRST = 5'd1,
      M_OBJ_FIRST = 5'd2,
      M_KEY       = 5'd3,
      M_COLON     = 5'd4,
      M_AFTER     = 5'd5,
      M_KSTR      = 5'd6,
      M_KESC      = 5'd7,
      M_KHEX      = 5'd8,
      M_VSTR      = 5'd9,
      M_VESC      = 5'd10,
      M_VHEX      = 5'd11,
      M_TRUE      = 5'd12,
      M_FALSE     = 5'd13,
      M_NULL      = 5'd14,
      M_N_SIGN    = 5'd15,
      M_N_ZERO    = 5'd16,
      M_N_INT     = 5'd17,
      M_N_DOT     = 5'd18,
      M_N_FRAC    = 5'd19,
      M_N_E       = 5'd20,
      M_N_ESIGN   = 5'd21,
      M_N_EXP     = 5'd22
   } mode_type;

   localparam logic [LEVEL_W-1:0] LVL_LIMIT = LEVEL_W'(NEST_LIMIT);
   localparam logic [LEVEL_W-1:0] LVL_MAX   = LEVEL_W'(NEST_LIMIT + 1);

   // Input register
   logic             s1_valid_ff;
   logic [7:0]       s1_byte_ff;
   logic             s1_last_ff;

   // Parser state
   mode_type             mode_ff, mode_in;
   logic [2:0]           lit_ff, lit_in;
   logic [2:0]           hex_ff, hex_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic                 err_ff, err_in;
   logic                 kind_ff [KIND_DEPTH];

   // Output register
   logic             rsp_valid_ff;
   logic             rsp_doc_ff;

   logic             out_free;
   logic             fire;
   logic             push_en;
   logic             push_kind;
   logic             doc_ok;

   // Byte classes
   logic [7:0]       c;
   logic             is_ws, is_digit, is_hex, is_exp, top_kind;
   logic [KIND_W-1:0] top_idx;

   // after-value and start-value outcomes, shared by several modes
   mode_type         av_mode, sv_mode;
   logic             av_fail, av_pop, sv_fail, sv_push, sv_kind;
   logic [2:0]       sv_lit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_doc_valid = rsp_doc_ff;

   assign c        = s1_byte_ff;
   assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_hex   = is_digit || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
                     ((c >= CH_UC_A) && (c <= CH_UC_F));
   assign is_exp   = (c == CH_LC_E) || (c == CH_UC_E);
   assign top_idx  = (lvl_ff == '0) ? '0 : KIND_W'(lvl_ff - LEVEL_W'(1));
   assign top_kind = kind_ff[top_idx];

   // What follows a finished value: whitespace, comma or the matching closer.
   always_comb begin
      av_mode = M_AFTER;
      av_fail = 1'b0;
      av_pop  = 1'b0;
      if (!is_ws) begin
         if ((lvl_ff == '0) || (lvl_ff > LVL_MAX)) begin
            av_fail = 1'b1;
         end else if (c == CH_COMMA) begin
            av_mode = top_kind ? M_KEY : M_VALUE;
         end else if (((c == CH_RBRACE) && top_kind) || ((c == CH_RBRACK) && !top_kind)) begin
            av_pop = 1'b1;
         end else begin
            av_fail = 1'b1;
         end
      end
   end

   // First byte of a value.
   always_comb begin
      sv_mode = mode_ff;
      sv_fail = 1'b0;
      sv_push = 1'b0;
      sv_kind = 1'b0;
      sv_lit  = lit_ff;
      if (lvl_ff > LVL_LIMIT) begin
         sv_fail = 1'b1;
      end else if (c == CH_QUOTE) begin
         sv_mode = M_VSTR;
      end else if (c == CH_LBRACE) begin
         sv_mode = M_OBJ_FIRST;
         sv_push = 1'b1;
         sv_kind = 1'b1;
      end else if (c == CH_LBRACK) begin
         sv_mode = M_ARR_FIRST;
         sv_push = 1'b1;
      end else if (c == CH_LC_T) begin
         sv_mode = M_TRUE;
         sv_lit  = 3'd1;
      end else if (c == CH_LC_F) begin
         sv_mode = M_FALSE;
         sv_lit  = 3'd1;
      end else if (c == CH_LC_N) begin
         sv_mode = M_NULL;
         sv_lit  = 3'd1;
      end else if (c == CH_MINUS) begin
         sv_mode = M_N_SIGN;
      end else if (c == CH_ZERO) begin
         sv_mode = M_N_ZERO;
      end else if ((c >= CH_ONE) && (c <= CH_NINE)) begin
         sv_mode = M_N_INT;
      end else begin
         sv_fail = 1'b1;
      end
   end

   // Parser next state for the byte in the input register.
   always_comb begin
      word_type wsel;
      logic     do_after;
      mode_type str_base;
      mode_type str_done;

      mode_in   = mode_ff;
      lit_in    = lit_ff;
      hex_in    = hex_ff;
      lvl_in    = lvl_ff;
      err_in    = err_ff;
      push_en   = 1'b0;
      push_kind = 1'b0;
      do_after  = 1'b0;
      wsel      = WORD_TRUE;
      str_base  = (mode_ff inside {M_KSTR, M_KESC, M_KHEX}) ? M_KSTR : M_VSTR;
      str_done  = (str_base == M_KSTR) ? M_COLON : M_AFTER;

      if (!err_ff) begin
         unique case (mode_ff)
            M_VALUE: begin
               if (!is_ws) begin
                  mode_in   = sv_mode;
                  lit_in    = sv_lit;
                  err_in    = sv_fail;
                  push_en   = sv_push;
                  push_kind = sv_kind;
               end
            end
            M_ARR_FIRST: begin
               if (!is_ws) begin
                  if (c == CH_RBRACK) begin
                     if (lvl_ff != '0) lvl_in = lvl_ff - LEVEL_W'(1);
                     mode_in = M_AFTER;
                  end else begin
                     mode_in   = sv_mode;
                     lit_in    = sv_lit;
                     err_in    = sv_fail;
                     push_en   = sv_push;
                     push_kind = sv_kind;
                  end
               end
            end
            M_OBJ_FIRST, M_KEY: begin
               if (!is_ws) begin
                  if (c == CH_QUOTE) begin
                     mode_in = M_KSTR;
                  end else if ((c == CH_RBRACE) && (mode_ff == M_OBJ_FIRST)) begin
                     if (lvl_ff != '0) lvl_in = lvl_ff - LEVEL_W'(1);
                     mode_in = M_AFTER;
                  end else begin
                     err_in = 1'b1;
                  end
               end
            end
            M_COLON: begin
               if (!is_ws) begin
                  if (c == CH_COLON) mode_in = M_VALUE;
                  else err_in = 1'b1;
               end
            end
            M_AFTER: do_after = 1'b1;
            M_KSTR, M_VSTR: begin
               if (c == CH_QUOTE) mode_in = str_done;
               else if (c < CTRL_LIMIT) err_in = 1'b1;
               else if (c == CH_BSLASH) mode_in = (str_base == M_KSTR) ? M_KESC : M_VESC;
            end
            M_KESC, M_VESC: begin
               if ((c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                   (c == CH_LC_B) || (c == CH_LC_F) || (c == CH_LC_N) ||
                   (c == CH_LC_R) || (c == CH_LC_T)) begin
                  mode_in = str_base;
               end else if (c == CH_LC_U) begin
                  hex_in  = HEX_DIGITS;
                  mode_in = (str_base == M_KSTR) ? M_KHEX : M_VHEX;
               end else begin
                  err_in = 1'b1;
               end
            end
            M_KHEX, M_VHEX: begin
               if (!is_hex || (hex_ff == 3'd0)) begin
                  err_in = 1'b1;
               end else begin
                  hex_in = hex_ff - 3'd1;
                  if (hex_ff == 3'd1) mode_in = str_base;
               end
            end
            M_TRUE, M_FALSE, M_NULL: begin
               wsel = (mode_ff == M_FALSE) ? WORD_FALSE :
                      (mode_ff == M_NULL)  ? WORD_NULL  : WORD_TRUE;
               if ((lit_ff >= word_len(wsel)) || (c != word_char(wsel, lit_ff))) begin
                  err_in = 1'b1;
               end else if ((lit_ff + 3'd1) == word_len(wsel)) begin
                  lit_in  = 3'd0;
                  mode_in = M_AFTER;
               end else begin
                  lit_in = lit_ff + 3'd1;
               end
            end
            M_N_SIGN: begin
               if (c == CH_ZERO) mode_in = M_N_ZERO;
               else if (is_digit) mode_in = M_N_INT;
               else err_in = 1'b1;
            end
            M_N_ZERO, M_N_INT: begin
               if (is_digit) begin
                  if (mode_ff == M_N_ZERO) err_in = 1'b1;
               end else if (c == CH_DOT) begin
                  mode_in = M_N_DOT;
               end else if (is_exp) begin
                  mode_in = M_N_E;
               end else begin
                  do_after = 1'b1;
               end
            end
            M_N_DOT: begin
               if (is_digit) mode_in = M_N_FRAC;
               else err_in = 1'b1;
            end
            M_N_FRAC: begin
               if (is_exp) mode_in = M_N_E;
               else if (!is_digit) do_after = 1'b1;
            end
            M_N_E: begin
               if ((c == CH_PLUS) || (c == CH_MINUS)) mode_in = M_N_ESIGN;
               else if (is_digit) mode_in = M_N_EXP;
               else err_in = 1'b1;
            end
            M_N_ESIGN: begin
               if (is_digit) mode_in = M_N_EXP;
               else err_in = 1'b1;
            end
            M_N_EXP: begin
               if (!is_digit) do_after = 1'b1;
            end
            default: err_in = 1'b1;
         endcase

         // Close out a value: separator, closer or whitespace.
         if (do_after) begin
            mode_in = av_mode;
            if (av_fail) err_in = 1'b1;
            if (av_pop && (lvl_ff != '0)) lvl_in = lvl_ff - LEVEL_W'(1);
         end
         if (push_en) lvl_in = lvl_ff + LEVEL_W'(1);
      end

      doc_ok = !err_in && (lvl_in == '0) &&
               (mode_in inside {M_AFTER, M_N_ZERO, M_N_INT, M_N_FRAC, M_N_EXP});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= M_VALUE;
         lit_ff       <= 3'd0;
         hex_ff       <= 3'd0;
         lvl_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         // Input register: load whenever it is empty or draining this cycle.
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
            if (req_valid) begin
               s1_byte_ff <= req_in_byte;
               s1_last_ff <= req_last_byte;
            end
         end

         // Output register: load the verdict of a last byte, drop the verdict once taken.
         if (fire && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_doc_ff   <= doc_ok;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (fire) begin
            if (push_en) kind_ff[lvl_ff[KIND_W-1:0]] <= push_kind;
            if (s1_last_ff) begin
               // Start the next document clean.
               mode_ff <= M_VALUE;
               lit_ff  <= 3'd0;
               hex_ff  <= 3'd0;
               lvl_ff  <= '0;
               err_ff  <= 1'b0;
            end else begin
               mode_ff <= mode_in;
               lit_ff  <= lit_in;
               hex_ff  <= hex_in;
               lvl_ff  <= lvl_in;
               err_ff  <= err_in;
            end
         end
      end
   end

   // Nesting never passes one above the limit.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LVL_MAX)
      else $error("nesting level beyond limit");

   // A last byte leaves the parser clean.
   a_clean_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_last_ff) |=> (mode_ff == M_VALUE) && (lvl_ff == '0) && !err_ff)
      else $error("parser not clean after last byte");

   // A last byte that completes always produces a verdict.
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_last_ff) |=> rsp_valid_ff)
      else $error("missing verdict");

   // Backpressure only comes from a held verdict blocking a last byte.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");

   // Hex count is live only inside a unicode escape.
   a_hex_mode: assert property (@(posedge clock) disable iff (reset)
      (hex_ff != 3'd0) |-> ((mode_ff == M_KHEX) || (mode_ff == M_VHEX)))
      else $error("hex count outside escape");

   // Literal position is live only while matching a literal.
   a_lit_mode: assert property (@(posedge clock) disable iff (reset)
      (lit_ff != 3'd0) |-> ((mode_ff == M_TRUE) || (mode_ff == M_FALSE) ||
                            (mode_ff == M_NULL)))
      else $error("literal position outside literal");

endmodule

FILE: tb/sv/jsv_verdict_checker.sv
// Verdict checker for the JSON syntax checker: watches both channels, tracks the
// parser state per accepted byte and compares every verdict with the one predicted.
// Depends on jsv_pkg for the nesting limit, byte codes and hex digit count.
module jsv_verdict_checker
   import jsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_doc_valid,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [4:0] {
      P_VALUE, P_ARR_FIRST, P_OBJ_FIRST, P_KEY, P_COLON, P_AFTER,
      P_KSTR, P_KESC, P_KHEX, P_VSTR, P_VESC, P_VHEX,
      P_TRUE, P_FALSE, P_NULL,
      P_N_SIGN, P_N_ZERO, P_N_INT, P_N_DOT, P_N_FRAC, P_N_E, P_N_ESIGN, P_N_EXP
   } parse_mode_type;

   parse_mode_type mode;
   logic [2:0]  lit_pos;
   logic [2:0]  hex_owed;
   logic [4:0]  depth;
   logic        kind_stack [KIND_DEPTH];
   bit          bad;
   bit          verdict_queue [$];

   function automatic bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic bit is_dec(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_hexd(logic [7:0] c);
      return is_dec(c) || (c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F);
   endfunction

   function automatic void clear_parser();
      mode     = P_VALUE;
      lit_pos  = 3'd0;
      hex_owed = 3'd0;
      depth    = 5'd0;
      bad      = 1'b0;
   endfunction

   function automatic void open_level(logic kind);
      if (depth > NEST_LIMIT) begin
         bad = 1'b1;
      end else begin
         kind_stack[depth] = kind;
         depth = depth + 5'd1;
         mode = kind ? P_OBJ_FIRST : P_ARR_FIRST;
      end
   endfunction

   function automatic void close_level();
      if (depth > 0) depth = depth - 5'd1;
      mode = P_AFTER;
   endfunction

   function automatic void begin_value(logic [7:0] c);
      if (depth > NEST_LIMIT) bad = 1'b1;
      else if (c == CH_QUOTE) mode = P_VSTR;
      else if (c == CH_LBRACE) open_level(1'b1);
      else if (c == CH_LBRACK) open_level(1'b0);
      else if (c == CH_LC_T) begin
         mode = P_TRUE;
         lit_pos = 3'd1;
      end else if (c == CH_LC_F) begin
         mode = P_FALSE;
         lit_pos = 3'd1;
      end else if (c == CH_LC_N) begin
         mode = P_NULL;
         lit_pos = 3'd1;
      end else if (c == CH_MINUS) mode = P_N_SIGN;
      else if (c == CH_ZERO) mode = P_N_ZERO;
      else if (c >= CH_ONE && c <= CH_NINE) mode = P_N_INT;
      else bad = 1'b1;
   endfunction

   // A finished value must be followed by whitespace, a comma or the right closer.
   function automatic void follow_value(logic [7:0] c);
      logic kind;
      mode = P_AFTER;
      if (!is_space(c)) begin
         if (depth == 0) begin
            bad = 1'b1;
         end else begin
            kind = kind_stack[depth - 5'd1];
            if (c == CH_COMMA) mode = kind ? P_KEY : P_VALUE;
            else if ((c == CH_RBRACE && kind) || (c == CH_RBRACK && !kind)) close_level();
            else bad = 1'b1;
         end
      end
   endfunction

   function automatic void match_letter(logic [7:0] c);
      string word;
      case (mode)
         P_TRUE:  word = "true";
         P_FALSE: word = "false";
         default: word = "null";
      endcase
      if (lit_pos >= word.len() || c != word[lit_pos]) begin
         bad = 1'b1;
      end else begin
         lit_pos = lit_pos + 3'd1;
         if (lit_pos == word.len()) begin
            lit_pos = 3'd0;
            mode = P_AFTER;
         end
      end
   endfunction

   function automatic void string_byte(logic [7:0] c, bit key);
      if (mode == P_KSTR || mode == P_VSTR) begin
         if (c == CH_QUOTE) mode = key ? P_COLON : P_AFTER;
         else if (c < CTRL_LIMIT) bad = 1'b1;
         else if (c == CH_BSLASH) mode = key ? P_KESC : P_VESC;
      end else if (mode == P_KESC || mode == P_VESC) begin
         if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LC_B ||
             c == CH_LC_F || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T) begin
            mode = key ? P_KSTR : P_VSTR;
         end else if (c == CH_LC_U) begin
            hex_owed = HEX_DIGITS;
            mode = key ? P_KHEX : P_VHEX;
         end else begin
            bad = 1'b1;
         end
      end else begin
         if (!is_hexd(c) || hex_owed == 0) begin
            bad = 1'b1;
         end else begin
            hex_owed = hex_owed - 3'd1;
            if (hex_owed == 0) mode = key ? P_KSTR : P_VSTR;
         end
      end
   endfunction

   function automatic void number_byte(logic [7:0] c);
      bit d, e, done;
      d = is_dec(c);
      e = (c == CH_LC_E || c == CH_UC_E);
      done = 1'b1;
      case (mode)
         P_N_SIGN: begin
            if (c == CH_ZERO) mode = P_N_ZERO;
            else if (d) mode = P_N_INT;
            else bad = 1'b1;
         end
         P_N_ZERO, P_N_INT: begin
            if (d) begin
               if (mode == P_N_ZERO) bad = 1'b1;
            end else if (c == CH_DOT) mode = P_N_DOT;
            else if (e) mode = P_N_E;
            else done = 1'b0;
         end
         P_N_DOT: begin
            if (d) mode = P_N_FRAC;
            else bad = 1'b1;
         end
         P_N_FRAC: begin
            if (e) mode = P_N_E;
            else if (!d) done = 1'b0;
         end
         P_N_E: begin
            if (c == CH_PLUS || c == CH_MINUS) mode = P_N_ESIGN;
            else if (d) mode = P_N_EXP;
            else bad = 1'b1;
         end
         P_N_ESIGN: begin
            if (d) mode = P_N_EXP;
            else bad = 1'b1;
         end
         default: begin
            if (!d) done = 1'b0;
         end
      endcase
      if (!done) follow_value(c);
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      case (mode)
         P_VALUE: begin
            if (!is_space(c)) begin_value(c);
         end
         P_ARR_FIRST: begin
            if (!is_space(c)) begin
               if (c == CH_RBRACK) close_level();
               else begin_value(c);
            end
         end
         P_OBJ_FIRST, P_KEY: begin
            if (!is_space(c)) begin
               if (c == CH_QUOTE) mode = P_KSTR;
               else if (c == CH_RBRACE && mode == P_OBJ_FIRST) close_level();
               else bad = 1'b1;
            end
         end
         P_COLON: begin
            if (!is_space(c)) begin
               if (c == CH_COLON) mode = P_VALUE;
               else bad = 1'b1;
            end
         end
         P_AFTER:                  follow_value(c);
         P_KSTR, P_KESC, P_KHEX:   string_byte(c, 1'b1);
         P_VSTR, P_VESC, P_VHEX:   string_byte(c, 1'b0);
         P_TRUE, P_FALSE, P_NULL:  match_letter(c);
         P_N_SIGN, P_N_ZERO, P_N_INT, P_N_DOT,
         P_N_FRAC, P_N_E, P_N_ESIGN, P_N_EXP: number_byte(c);
         default:                  bad = 1'b1;
      endcase
   endfunction

   // Advance the parser on one byte; on the last byte queue the verdict and start clean.
   function automatic void predict_byte(logic [7:0] c, logic last);
      bit ok;
      if (!bad) parse_byte(c);
      if (last) begin
         ok = !bad && depth == 0 &&
              (mode == P_AFTER || mode == P_N_ZERO || mode == P_N_INT ||
               mode == P_N_FRAC || mode == P_N_EXP);
         verdict_queue.push_back(ok);
         clear_parser();
      end
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         clear_parser();
         verdict_queue.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $error("doc_valid: no verdict expected, actual %0b", rsp_doc_valid);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_doc_valid !== want) begin
                  $error("doc_valid mismatch: expected %0b, actual %0b", want, rsp_doc_valid);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_byte(req_in_byte, req_last_byte);
         pending_count <= verdict_queue.size();
      end
   end

endmodule

FILE: tb/sv/json_syntax_validator_top_test.sv
// Top of the JSON syntax checker testbench: clock, reset, byte stimulus, receiver
// stalls and the final verdict. Depends on jsv_pkg, json_syntax_validator_top and
// jsv_verdict_checker.
module json_syntax_validator_top_test
   import jsv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    RANDOM_BYTES = 1680;
   localparam int    CYCLE_LIMIT  = 200000;
   localparam int    DRAIN_CYCLES = 12;
   localparam string ESCAPES      = "\"\\/bfnrt";
   localparam string HEX_SET      = "0123456789abcdefABCDEF";
   localparam string NOISE_SET    = " \t\r\n{}[],:\"\\-+.0123456789eEtrufalsnbu/";

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte   = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_doc_valid;

   int fail_count;
   int pending_count;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int bytes_sent  = 0;
   int cycle_count = 0;

   // Document under construction, plus the open containers of the generator.
   logic [7:0] doc_bytes [$];
   logic       open_kinds [$];
   int         open_counts [$];

   json_syntax_validator_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_doc_valid (rsp_doc_valid)
   );

   jsv_verdict_checker verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_doc_valid (rsp_doc_valid),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver side: stall at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: end the run if the traffic never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("json_syntax_validator_top_test NOT OK");
      $finish;
   end

   // Offer one byte and hold it until accepted. Idle gaps come first, so valid
   // never reacts to stall and a stalled transaction keeps its payload.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_doc();
      foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      bytes_sent += doc_bytes.size();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      doc_bytes.delete();
      push_text(s);
      send_doc();
   endtask

   function automatic logic [7:0] pick_noise_byte();
      if ($urandom_range(0, 1) == 0) return NOISE_SET[$urandom_range(0, NOISE_SET.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Sprinkle optional whitespace between tokens.
   task automatic add_ws();
      string spaces;
      spaces = " \t\r\n";
      if ($urandom_range(0, 9) < 3) begin
         repeat ($urandom_range(1, 2)) doc_bytes.push_back(spaces[$urandom_range(0, 3)]);
      end
   endtask

   // String with plain ASCII, high bytes, short escapes and unicode escapes.
   task automatic add_string();
      int         pick;
      logic [7:0] c;
      doc_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            c = 8'($urandom_range(CH_SPACE, 8'h7E));
            if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LC_A;
            doc_bytes.push_back(c);
         end else if (pick < 7) begin
            doc_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
         end else if (pick < 9) begin
            doc_bytes.push_back(CH_BSLASH);
            doc_bytes.push_back(ESCAPES[$urandom_range(0, ESCAPES.len() - 1)]);
         end else begin
            doc_bytes.push_back(CH_BSLASH);
            doc_bytes.push_back(CH_LC_U);
            repeat (4) doc_bytes.push_back(HEX_SET[$urandom_range(0, HEX_SET.len() - 1)]);
         end
      end
      doc_bytes.push_back(CH_QUOTE);
   endtask

   // Well-formed number: optional sign, integer part, optional fraction and exponent.
   task automatic add_number();
      if ($urandom_range(0, 2) == 0) doc_bytes.push_back(CH_MINUS);
      if ($urandom_range(0, 3) == 0) begin
         doc_bytes.push_back(CH_ZERO);
      end else begin
         doc_bytes.push_back(8'($urandom_range(CH_ONE, CH_NINE)));
         repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      if ($urandom_range(0, 1) == 0) begin
         doc_bytes.push_back(CH_DOT);
         repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      if ($urandom_range(0, 9) < 3) begin
         doc_bytes.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
         case ($urandom_range(0, 2))
            0: doc_bytes.push_back(CH_PLUS);
            1: doc_bytes.push_back(CH_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
   endtask

   // Start a value: open a container while depth allows, else emit a scalar.
   task automatic add_value(input int max_depth);
      logic kind;
      if (open_kinds.size() < max_depth && $urandom_range(0, 9) < 4) begin
         kind = 1'($urandom_range(0, 1));
         doc_bytes.push_back(kind ? CH_LBRACE : CH_LBRACK);
         open_kinds.push_back(kind);
         open_counts.push_back(0);
      end else begin
         case ($urandom_range(0, 2))
            0: add_string();
            1: add_number();
            default: begin
               case ($urandom_range(0, 2))
                  0: push_text("true");
                  1: push_text("false");
                  default: push_text("null");
               endcase
            end
         endcase
      end
   endtask

   // Build one well-formed document without recursion: keep a stack of the open
   // containers and either add an element or close the innermost one.
   task automatic build_valid_doc(input int max_depth);
      int top_ix;
      open_kinds.delete();
      open_counts.delete();
      add_ws();
      add_value(max_depth);
      while (open_kinds.size() > 0) begin
         top_ix = open_kinds.size() - 1;
         add_ws();
         if (open_counts[top_ix] >= $urandom_range(0, 3)) begin
            doc_bytes.push_back(open_kinds[top_ix] ? CH_RBRACE : CH_RBRACK);
            void'(open_kinds.pop_back());
            void'(open_counts.pop_back());
         end else begin
            if (open_counts[top_ix] > 0) begin
               doc_bytes.push_back(CH_COMMA);
               add_ws();
            end
            if (open_kinds[top_ix]) begin
               add_string();
               add_ws();
               doc_bytes.push_back(CH_COLON);
               add_ws();
            end
            open_counts[top_ix]++;
            add_value(max_depth);
         end
      end
      add_ws();
   endtask

   // Straight chain of nested containers around the nesting limit.
   task automatic build_nest(input int levels, input bit with_scalar, input bit mixed);
      logic nest_kinds [$];
      for (int i = 0; i < levels; i++) begin
         if (mixed && $urandom_range(0, 1) == 1) begin
            push_text("{\"k\":");
            nest_kinds.push_back(1'b1);
         end else begin
            doc_bytes.push_back(CH_LBRACK);
            nest_kinds.push_back(1'b0);
         end
      end
      if (with_scalar) doc_bytes.push_back(8'($urandom_range(CH_ONE, CH_NINE)));
      for (int i = levels - 1; i >= 0; i--) begin
         doc_bytes.push_back(nest_kinds[i] ? CH_RBRACE : CH_RBRACK);
      end
   endtask

   // Mostly well-formed documents with random content; some are broken by a
   // corrupted or inserted byte or a cut-off tail, the rest are deep chains or plain noise.
   task automatic make_random_doc();
      int pick;
      int pos;
      int keep;
      doc_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         build_nest($urandom_range(14, 19), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
         build_valid_doc($urandom_range(0, 3) == 0 ? 4 : 2);
         pick = $urandom_range(0, 99);
         pos = $urandom_range(0, doc_bytes.size() - 1);
         if (pick < 12) begin
            doc_bytes[pos] = pick_noise_byte();
         end else if (pick < 18) begin
            keep = $urandom_range(1, doc_bytes.size());
            while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
         end else if (pick < 24) begin
            doc_bytes.insert(pos, pick_noise_byte());
         end
      end else begin
         repeat ($urandom_range(1, 6)) doc_bytes.push_back(pick_noise_byte());
      end
   endtask

   // Directed documents: every construct, each escape, the field extremes and the
   // special cases (too deep, after an error, high bytes, number or literal end,
   // early end, whitespace only).
   task automatic run_directed();
      send_text("{}");
      send_text(" [ ] ");
      send_text("{\"a\":[1,-0.5e+3,2E-1,0,true,false,null,\"x\"],\"b\":{}}");
      send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u09aF\"");
      send_text("[1,]");
      send_text("{\"a\" 1}");
      send_text("{1:2}");
      send_text("01");
      send_text("1.");
      send_text("-1e+");
      send_text("[truex]");
      send_text("12a");
      send_text("[1}");
      send_text("   ");
      send_text("[\"ab");
      send_text("\"\\u12\"");
      send_text("\"\\x\"");
      send_text("1 2");
      send_text("[x] ]]] junk");
      // High bytes pass inside a string, fail bare; control bytes fail in a string.
      doc_bytes.delete();
      push_text("[\"");
      doc_bytes.push_back(8'h80);
      doc_bytes.push_back(8'hFF);
      push_text("\"]");
      send_doc();
      doc_bytes.delete();
      doc_bytes.push_back(8'hFF);
      send_doc();
      doc_bytes.delete();
      push_text("\"a");
      doc_bytes.push_back(8'h00);
      push_text("\"");
      send_doc();
      // Deepest legal chain, then one level too many, then a value too deep.
      doc_bytes.delete();
      build_nest(NEST_LIMIT + 1, 1'b0, 1'b0);
      send_doc();
      doc_bytes.delete();
      build_nest(NEST_LIMIT + 2, 1'b0, 1'b0);
      send_doc();
      doc_bytes.delete();
      build_nest(NEST_LIMIT + 1, 1'b1, 1'b0);
      send_doc();
   endtask

   initial begin
      int random_start;
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random part: cycle through idle and stall phases as the byte count advances.
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         phase = ((bytes_sent - random_start) * 8 / RANDOM_BYTES) % 4;
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 45;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 45;
            end
            default: begin
               idle_pct  = 18;
               stall_pct = 18;
            end
         endcase
         make_random_doc();
         send_doc();
      end
      req_valid <= 1'b0;

      // Drain: let the pending count catch up, wait until every verdict is in,
      // then keep watching the block so that any stray result shows.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("json_syntax_validator_top_test OK");
      end else begin
         $display("json_syntax_validator_top_test NOT OK");
      end
      $finish;
   end

endmodule

FILE: json_syntax_validator_top.f
src/jsv_pkg.sv
src/json_syntax_validator_top.sv
tb/sv/jsv_verdict_checker.sv
tb/sv/json_syntax_validator_top_test.sv
